FILE: rtl/bts_pkg.sv
package bts_pkg;

   // configuration register indexes
   localparam logic CSR_TEX_WIDTH  = 1'b0;
   localparam logic CSR_TEX_HEIGHT = 1'b1;

   localparam int DIM_W     = 9;    // width/height register width
   localparam int DIM_MAX   = 256;
   localparam int CORNER_AW = 16;   // x + y * w stays below 2^16
   localparam int COORD_W   = 24;
   localparam int TEXEL_W   = 24;
   localparam int INDEX_W   = 16;

endpackage

FILE: rtl/bts_ram.sv
module bts_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                                      clock,
   input  logic                                      en,
   input  logic                                      we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (en) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/bilinear_texture_sampler_wrap.sv
// Bilinear texture sampler with wrap-around tiling.
// req_ channel: one word per item. tuser = func (0 writes texel_color at
// texel_index, 1 samples at u_coord,v_coord in signed fixed point with
// FRAC_BITS fraction bits). A write gives no rsp_ word; a sample gives one.
// rsp_ channel: red, green, blue of the blended sample.
// csr_ channel: index 0 = texture width, 1 = height; the user writes them
// only while idle, which the block does not enforce. Throughput: one item
// per cycle while the output is not stalled. Four copies of the texture
// store take every write, so the four corners are read in the same cycle.
// An item passes stage 0, NST = ceil((24 - FRAC_BITS) / 4) floored-modulo
// stages (four remainder bits per stage), then stages A to F.
// Reset clears the valid bits of all stages and sets width and height to 1;
// texture contents are undefined until written.
// When rsp_tready is low with a word pending, the whole pipeline holds and
// req_tready drops in the same cycle; nothing is lost or repeated.
module bilinear_texture_sampler_wrap #(
   parameter int TEX_WORDS = 65536,
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // texel_index[15:0], texel_color[39:16], u_coord[63:40], v_coord[87:64]
   input  logic [87:0] req_tdata,
   // func[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // red[7:0], green[15:8], blue[23:16]
   output logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_data
);
   import bts_pkg::*;

   localparam int IPW    = COORD_W - FRAC_BITS;
   localparam int NST    = (IPW + 3) / 4;
   localparam int MW     = 4 * NST;
   localparam int RAM_AW = TEX_WORDS > 1 ? $clog2(TEX_WORDS) : 1;
   localparam int LW     = FRAC_BITS + 9;

   typedef struct packed {
      logic                 func;
      logic [INDEX_W-1:0]   idx;
      logic [TEXEL_W-1:0]   color;
      logic [FRAC_BITS-1:0] fu;
      logic [FRAC_BITS-1:0] fv;
      logic [DIM_W-1:0]     w;
      logic [DIM_W-1:0]     h;
      logic                 un;
      logic                 vn;
      logic [MW-1:0]        um;
      logic [MW-1:0]        vm;
      logic [7:0]           ur;
      logic [7:0]           vr;
   } tile_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      if (d == '0) return DIM_W'(1);
      if (d > DIM_W'(DIM_MAX)) return DIM_W'(DIM_MAX);
      return d;
   endfunction

   function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [FRAC_BITS-1:0] f);
      logic [FRAC_BITS:0] g;
      logic [LW-1:0]      s;
      g = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, f};
      s = LW'(a) * LW'(g) + LW'(b) * LW'(f);
      return s[FRAC_BITS+7:FRAC_BITS];
   endfunction

   logic adv;

   // configuration
   logic [DIM_W-1:0] tex_w_ff, tex_h_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_w_ff <= DIM_W'(1);
         tex_h_ff <= DIM_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TEX_WIDTH:  tex_w_ff <= csr_data;
            CSR_TEX_HEIGHT: tex_h_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stage 0: split coordinates, take magnitudes
   tile_type tile_in;
   tile_type tile_ff [NST+1];
   logic     tv_ff   [NST+1];

   always_comb begin
      logic [IPW-1:0] ipu, ipv;
      ipu = req_tdata[63:40+FRAC_BITS];
      ipv = req_tdata[87:64+FRAC_BITS];
      tile_in.func  = req_tuser;
      tile_in.idx   = req_tdata[15:0];
      tile_in.color = req_tdata[39:16];
      tile_in.fu    = req_tdata[40 +: FRAC_BITS];
      tile_in.fv    = req_tdata[64 +: FRAC_BITS];
      tile_in.w     = clamp_dim(tex_w_ff);
      tile_in.h     = clamp_dim(tex_h_ff);
      tile_in.un    = ipu[IPW-1];
      tile_in.vn    = ipv[IPW-1];
      tile_in.um    = MW'(ipu[IPW-1] ? ~ipu + IPW'(1) : ipu);
      tile_in.vm    = MW'(ipv[IPW-1] ? ~ipv + IPW'(1) : ipv);
      tile_in.ur    = '0;
      tile_in.vr    = '0;
   end

   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff[0] <= 1'b0;
      end else if (adv) begin
         tv_ff[0] <= req_tvalid;
      end
      if (adv) begin
         tile_ff[0] <= tile_in;
      end
   end

   // remainder stages: four magnitude bits each, MSB first
   for (genvar j = 0; j < NST; j++) begin : g_mod
      tile_type nxt_in;

      always_comb begin
         logic [8:0] tu, tv;
         logic [7:0] ru, rv;
         nxt_in = tile_ff[j];
         ru = tile_ff[j].ur;
         rv = tile_ff[j].vr;
         for (int k = 0; k < 4; k++) begin
            tu = {ru, tile_ff[j].um[MW-1-4*j-k]};
            if (tu >= tile_ff[j].w) tu = tu - tile_ff[j].w;
            ru = tu[7:0];
            tv = {rv, tile_ff[j].vm[MW-1-4*j-k]};
            if (tv >= tile_ff[j].h) tv = tv - tile_ff[j].h;
            rv = tv[7:0];
         end
         nxt_in.ur = ru;
         nxt_in.vr = rv;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tv_ff[j+1] <= 1'b0;
         end else if (adv) begin
            tv_ff[j+1] <= tv_ff[j];
         end
         if (adv) begin
            tile_ff[j+1] <= nxt_in;
         end
      end
   end

   // stage A: floored modulo and wrapped neighbor
   tile_type       tl;
   logic [8:0]     xs, ys;
   logic [7:0]     x0_in, x1_in, y0_in, y1_in;
   logic           av_ff;
   logic [7:0]     x0_ff, x1_ff, y0_ff, y1_ff;
   logic [DIM_W-1:0] aw_ff;
   logic           afunc_ff;
   logic [INDEX_W-1:0] aidx_ff;
   logic [TEXEL_W-1:0] acolor_ff;
   logic [FRAC_BITS-1:0] afu_ff, afv_ff;

   assign tl = tile_ff[NST];

   always_comb begin
      x0_in = (tl.un && tl.ur != '0) ? 8'(tl.w - 9'(tl.ur)) : tl.ur;
      y0_in = (tl.vn && tl.vr != '0) ? 8'(tl.h - 9'(tl.vr)) : tl.vr;
      xs    = 9'(x0_in) + 9'd1;
      ys    = 9'(y0_in) + 9'd1;
      x1_in = (xs >= tl.w) ? 8'd0 : xs[7:0];
      y1_in = (ys >= tl.h) ? 8'd0 : ys[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         av_ff <= 1'b0;
      end else if (adv) begin
         av_ff <= tv_ff[NST];
      end
      if (adv) begin
         x0_ff <= x0_in;  x1_ff <= x1_in;
         y0_ff <= y0_in;  y1_ff <= y1_in;
         aw_ff <= tl.w;
         afunc_ff  <= tl.func;
         aidx_ff   <= tl.idx;
         acolor_ff <= tl.color;
         afu_ff    <= tl.fu;
         afv_ff    <= tl.fv;
      end
   end

   // stage B: row offsets
   logic           bv_ff;
   logic [CORNER_AW-1:0] r0_ff, r1_ff;
   logic [7:0]     bx0_ff, bx1_ff;
   logic           bfunc_ff;
   logic [INDEX_W-1:0] bidx_ff;
   logic [TEXEL_W-1:0] bcolor_ff;
   logic [FRAC_BITS-1:0] bfu_ff, bfv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= 1'b0;
      end else if (adv) begin
         bv_ff <= av_ff;
      end
      if (adv) begin
         r0_ff <= CORNER_AW'(17'(y0_ff) * 17'(aw_ff));
         r1_ff <= CORNER_AW'(17'(y1_ff) * 17'(aw_ff));
         bx0_ff <= x0_ff;  bx1_ff <= x1_ff;
         bfunc_ff  <= afunc_ff;
         bidx_ff   <= aidx_ff;
         bcolor_ff <= acolor_ff;
         bfu_ff    <= afu_ff;
         bfv_ff    <= afv_ff;
      end
   end

   // stage C: corner addresses
   logic           cv_ff;
   logic [CORNER_AW-1:0] ca_ff [4];
   logic           cfunc_ff;
   logic [INDEX_W-1:0] cidx_ff;
   logic [TEXEL_W-1:0] ccolor_ff;
   logic [FRAC_BITS-1:0] cfu_ff, cfv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= 1'b0;
      end else if (adv) begin
         cv_ff <= bv_ff;
      end
      if (adv) begin
         ca_ff[0] <= r0_ff + CORNER_AW'(bx0_ff);
         ca_ff[1] <= r0_ff + CORNER_AW'(bx1_ff);
         ca_ff[2] <= r1_ff + CORNER_AW'(bx0_ff);
         ca_ff[3] <= r1_ff + CORNER_AW'(bx1_ff);
         cfunc_ff  <= bfunc_ff;
         cidx_ff   <= bidx_ff;
         ccolor_ff <= bcolor_ff;
         cfu_ff    <= bfu_ff;
         cfv_ff    <= bfv_ff;
      end
   end

   // stage D: texture read; writes land here too so item order holds
   logic           wr_en;
   logic           dv_ff, dfunc_ff;
   logic [3:0]     doob_ff;
   logic [FRAC_BITS-1:0] dfu_ff, dfv_ff;
   logic [TEXEL_W-1:0]   q_raw [4];
   logic [TEXEL_W-1:0]   q     [4];

   assign wr_en = adv && cv_ff && !cfunc_ff && (32'(cidx_ff) < 32'(TEX_WORDS));

   for (genvar c = 0; c < 4; c++) begin : g_copy
      bts_ram #(.WIDTH(TEXEL_W), .DEPTH(TEX_WORDS)) u_ram (
         .clock (clock),
         .en    (adv),
         .we    (wr_en),
         .waddr (RAM_AW'(cidx_ff)),
         .wdata (ccolor_ff),
         .raddr (RAM_AW'(ca_ff[c])),
         .rdata (q_raw[c])
      );

      assign q[c] = doob_ff[c] ? '0 : q_raw[c];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= 1'b0;
      end else if (adv) begin
         dv_ff <= cv_ff;
      end
      if (adv) begin
         dfunc_ff <= cfunc_ff;
         dfu_ff   <= cfu_ff;
         dfv_ff   <= cfv_ff;
         for (int c = 0; c < 4; c++) begin
            doob_ff[c] <= 32'(ca_ff[c]) >= 32'(TEX_WORDS);
         end
      end
   end

   // stage E: blend along x
   logic       ev_ff, efunc_ff;
   logic [7:0] top_ff [3];
   logic [7:0] bot_ff [3];
   logic [FRAC_BITS-1:0] efv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_ff <= 1'b0;
      end else if (adv) begin
         ev_ff <= dv_ff;
      end
      if (adv) begin
         efunc_ff <= dfunc_ff;
         efv_ff   <= dfv_ff;
         for (int c = 0; c < 3; c++) begin
            top_ff[c] <= lerp8(q[0][8*c +: 8], q[1][8*c +: 8], dfu_ff);
            bot_ff[c] <= lerp8(q[2][8*c +: 8], q[3][8*c +: 8], dfu_ff);
         end
      end
   end

   // stage F: blend along y into the output word
   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff;

   assign adv = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ev_ff && efunc_ff;
      end
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            rsp_data_ff[8*c +: 8] <= lerp8(top_ff[c], bot_ff[c], efv_ff);
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_rsp_from_sample: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(ev_ff && efunc_ff))
      else $error("response without a sample in the last stage");

   a_x_in_range: assert property (@(posedge clock) disable iff (reset)
      av_ff |-> (9'(x0_ff) < aw_ff && 9'(x1_ff) < aw_ff))
      else $error("tiled x outside texture width");

   a_x_wrap: assert property (@(posedge clock) disable iff (reset)
      av_ff |-> (x1_ff == 8'd0 || x1_ff == x0_ff + 8'd1))
      else $error("x neighbor neither next texel nor wrapped");

   a_no_write_on_sample: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (cv_ff && !cfunc_ff))
      else $error("texture written by a sample");

endmodule

FILE: tb/tb_bilinear_texture_sampler_wrap.sv
`default_nettype none

module tb_bilinear_texture_sampler_wrap;
   import bts_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 8;
   localparam int LATENCY = 10;

   typedef struct packed {
      logic        func;
      logic [15:0] texel_index;
      logic [23:0] texel_color;
      logic [23:0] u_coord;
      logic [23:0] v_coord;
   } req_word_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [8:0]  csr_data = '0;

   bilinear_texture_sampler_wrap dut (.*);

   always #10 clock = ~clock;

   // predictor state
   logic [23:0] texels [int];
   int unsigned tex_w = 1, tex_h = 1;

   req_word_type pending_words[$];
   rgb_type      expected_rgb[$];
   int        errors = 0;
   int        burst_left = 0, gap_left = 0;
   bit        drive_enable = 1'b0;
   bit        req_taken = 1'b0;
   int        stall_mode = 0;
   int unsigned rsp_cycle = 0;

   function automatic void add_word(req_word_type w);
      pending_words = {pending_words, w};
   endfunction

   function automatic int unsigned clamp_dim(int unsigned d);
      if (d < 1) return 1;
      if (d > DIM_MAX) return DIM_MAX;
      return d;
   endfunction

   function automatic void tile(input logic [23:0] raw, input int unsigned dim,
                                output int unsigned lo, output int unsigned hi,
                                output int unsigned fr);
      longint s, ip, r;
      s = longint'($signed(raw));
      ip = s >>> FRAC;             // arithmetic shift is floor division
      fr = int'(s - (ip << FRAC));
      r = ip % longint'(dim);
      if (r < 0) r += dim;
      lo = int'(r);
      hi = (lo + 1 >= dim) ? 0 : lo + 1;
   endfunction

   function automatic logic [23:0] texel_at(int unsigned a);
      if (a >= 65536 || !texels.exists(a)) return '0;
      return texels[a];
   endfunction

   function automatic logic [7:0] blend(logic [7:0] a, logic [7:0] b, int unsigned f);
      int unsigned t;
      t = (a * ((1 << FRAC) - f) + b * f) >> FRAC;
      return t[7:0];
   endfunction

   function automatic rgb_type sample_texture(req_word_type w);
      int unsigned wd, ht, x0, x1, y0, y1, fu, fv;
      logic [23:0] q00, q10, q01, q11;
      logic [7:0] ch [3];
      wd = clamp_dim(tex_w);
      ht = clamp_dim(tex_h);
      tile(w.u_coord, wd, x0, x1, fu);
      tile(w.v_coord, ht, y0, y1, fv);
      q00 = texel_at(x0 + y0 * wd);
      q10 = texel_at(x1 + y0 * wd);
      q01 = texel_at(x0 + y1 * wd);
      q11 = texel_at(x1 + y1 * wd);
      for (int c = 0; c < 3; c++) begin
         ch[c] = blend(blend(q00[8*c +: 8], q10[8*c +: 8], fu),
                       blend(q01[8*c +: 8], q11[8*c +: 8], fu), fv);
      end
      return '{red: ch[0], green: ch[1], blue: ch[2]};
   endfunction

   // driver
   always @(negedge clock) begin
      if (req_tvalid && !req_taken) begin
         // hold the word
      end else if (drive_enable && pending_words.size() > 0) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            req_word_type w;
            w = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= w.func;
            req_tdata <= {w.v_coord, w.u_coord, w.texel_color, w.texel_index};
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end else
         req_tvalid <= 1'b0;
      rsp_cycle++;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= (rsp_cycle % 7) > 2;
      endcase
      if (rsp_cycle % 200 == 0) stall_mode = $urandom_range(0, 2);
   end

   // input monitor: predict on accept
   always @(posedge clock) begin
      req_taken = req_tvalid && req_tready;
      if (!reset && req_taken) begin
         req_word_type w;
         w = '{func: req_tuser, texel_index: req_tdata[15:0],
               texel_color: req_tdata[39:16], u_coord: req_tdata[63:40],
               v_coord: req_tdata[87:64]};
         if (w.func) expected_rgb = {expected_rgb, sample_texture(w)};
         else texels[w.texel_index] = w.texel_color;
      end
   end

   // output monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rgb_type e;
         if (expected_rgb.size() == 0) begin
            $error("unexpected rsp word %h", rsp_tdata);
            errors++;
         end else begin
            e = expected_rgb.pop_front();
            if (rsp_tdata[7:0] !== e.red) begin
               $error("red expected %h actual %h", e.red, rsp_tdata[7:0]); errors++;
            end
            if (rsp_tdata[15:8] !== e.green) begin
               $error("green expected %h actual %h", e.green, rsp_tdata[15:8]); errors++;
            end
            if (rsp_tdata[23:16] !== e.blue) begin
               $error("blue expected %h actual %h", e.blue, rsp_tdata[23:16]); errors++;
            end
         end
      end
   end

   task automatic csr_write(logic idx, logic [8:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_TEX_WIDTH) tex_w = val; else tex_h = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      drive_enable = 1'b1;
      wait (pending_words.size() == 0);
      @(posedge clock);
      while (req_tvalid) @(posedge clock);
      drive_enable = 1'b0;
      wait (expected_rgb.size() == 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic req_word_type texel_write(int unsigned idx, logic [23:0] col);
      return '{func: 1'b0, texel_index: idx[15:0], texel_color: col,
               u_coord: 24'($urandom), v_coord: 24'($urandom)};
   endfunction

   function automatic req_word_type sample_at(logic [23:0] u, logic [23:0] v);
      return '{func: 1'b1, texel_index: 16'($urandom), texel_color: 24'($urandom),
               u_coord: u, v_coord: v};
   endfunction

   // write every texel of the tiled area so no unwritten texel is read
   task automatic fill_texture(int unsigned wd, int unsigned ht, bit extremes);
      for (int unsigned i = 0; i < clamp_dim(wd) * clamp_dim(ht); i++)
         add_word(texel_write(i, extremes ? ((i % 2) ? 24'hFFFFFF : 24'h0)
                                          : 24'($urandom)));
   endtask

   task automatic run_phase(logic [8:0] wd, logic [8:0] ht, int n_items);
      csr_write(CSR_TEX_WIDTH, wd);
      csr_write(CSR_TEX_HEIGHT, ht);
      fill_texture(wd, ht, 1'b0);
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 4) == 0)
            add_word(texel_write(
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                  : $urandom_range(0, clamp_dim(wd) * clamp_dim(ht) - 1),
               24'($urandom)));
         else if ($urandom_range(0, 2) == 0)
            add_word(sample_at(24'($urandom), 24'($urandom)));
         else
            add_word(sample_at(24'($urandom_range(0, 4095) - 2048),
                               24'($urandom_range(0, 4095) - 2048)));
      end
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset sizes of 1x1, then 0 used as 1, extreme coordinates
      add_word(texel_write(0, 24'hFFFFFF));
      add_word(texel_write(16'hFFFF, 24'h123456));
      add_word(sample_at(24'h000000, 24'h000000));
      add_word(sample_at(24'h7FFFFF, 24'h800000));
      drain();
      csr_write(CSR_TEX_WIDTH, 9'd0);
      csr_write(CSR_TEX_HEIGHT, 9'd2);
      fill_texture(1, 2, 1'b1);
      add_word(sample_at(24'h0000FF, 24'h000080));
      add_word(sample_at(24'h800000, 24'h7FFFFF));
      add_word(sample_at(24'hFFFF01, 24'h0001FF));
      add_word(sample_at(24'h555555, 24'hAAAAAA));
      add_word(sample_at(24'hAAAAAA, 24'h555555));
      drain();

      // width above 256 is used as 256: samples near the right edge wrap to 0
      csr_write(CSR_TEX_WIDTH, 9'd511);
      csr_write(CSR_TEX_HEIGHT, 9'd1);
      add_word(texel_write(0, 24'($urandom)));
      add_word(texel_write(1, 24'($urandom)));
      add_word(texel_write(2, 24'($urandom)));
      add_word(texel_write(254, 24'($urandom)));
      add_word(texel_write(255, 24'($urandom)));
      add_word(sample_at(24'hFFFE40, 24'($urandom)));
      add_word(sample_at(24'hFFFF80, 24'($urandom)));
      add_word(sample_at(24'h0000C0, 24'($urandom)));
      add_word(sample_at(24'h000110, 24'($urandom)));
      add_word(sample_at(24'h00FFA0, 24'($urandom)));
      drain();

      run_phase(9'd3, 9'd5, 50);
      run_phase(9'd40, 9'd1, 50);
      run_phase(9'd1, 9'd32, 50);
      run_phase(9'd7, 9'd0, 50);
      run_phase(9'd9, 9'd6, 50);

      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
